// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file hf_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent implication checked on every rising clock edge outside reset.
`define HF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same, for implications whose consequent is checked in the cycle after the antecedent.
`define HF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) \
    else $error(msg);

`endif

// File: sv/hf_pkg.sv
// ----------------------------------------------------------------------------
// hf_pkg
// Shared types, constants and helpers of the heightfield normal unit.
// ----------------------------------------------------------------------------
package hf_pkg;

  localparam int MaxCells = 64;
  localparam int RowSlots = MaxCells + 1;
  localparam int MemDepth = 2 * RowSlots;
  localparam int AddrW    = 8;
  localparam int CntW     = 7;
  localparam int HW       = 24;
  localparam int DhW      = 25;
  localparam int SpW      = 16;
  localparam int DistW    = 17;
  localparam int MagW     = 41;
  localparam int QW       = 15;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_CELLS   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SPACING = 2'd1;

  // one vertex to be normalized
  typedef struct packed {
    logic [CntW-1:0]       x;
    logic [CntW-1:0]       y;
    logic signed [DhW-1:0] dhx;
    logic signed [DhW-1:0] dhy;
    logic                  kx2;   // x neighbours two cells apart
    logic                  ky2;   // y neighbours two cells apart
    logic [SpW-1:0]        sp;
    logic                  last;
    logic                  done;
  } job_t;

  typedef struct packed {
    logic [CntW-1:0]    x;
    logic [CntW-1:0]    y;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic [QW-1:0]      nz;
    logic [QW-1:0]      tx;
    logic signed [15:0] tz;
    logic               last;
    logic               done;
  } res_t;

  function automatic logic [AddrW-1:0] mem_addr(input logic par, input logic [CntW-1:0] col);
    logic [AddrW-1:0] base;
    base = par ? AddrW'(RowSlots) : '0;
    return base + {1'b0, col};
  endfunction

endpackage

// File: sv/hf_front.sv
// ----------------------------------------------------------------------------
// hf_front
// Takes heights, keeps the two-row line store and issues vertex jobs.
// ----------------------------------------------------------------------------
module hf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [hf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [hf_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                          push_i,
  output logic                          busy_o,
  input  logic [hf_pkg::HW-1:0]         height_i,
  output logic                          job_push_o,
  output hf_pkg::job_t                  job_o,
  input  logic                          job_full_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RA   = 4'd1;
  localparam logic [3:0] S_RB   = 4'd2;
  localparam logic [3:0] S_RC   = 4'd3;
  localparam logic [3:0] S_CC   = 4'd4;
  localparam logic [3:0] S_J1   = 4'd5;
  localparam logic [3:0] S_RD   = 4'd6;
  localparam logic [3:0] S_RE   = 4'd7;
  localparam logic [3:0] S_RF   = 4'd8;
  localparam logic [3:0] S_RG   = 4'd9;
  localparam logic [3:0] S_CG   = 4'd10;
  localparam logic [3:0] S_J2   = 4'd11;
  localparam logic [3:0] S_J3   = 4'd12;
  localparam logic [3:0] S_WR   = 4'd13;

  logic [3:0] state_q, state_d;
  logic [hf_pkg::CntW-1:0] cpe_q, col_q, row_q, n_eff;
  logic [hf_pkg::SpW-1:0]  sp_q;
  logic [hf_pkg::CntW-1:0] cx_q, cy_q, n_q;
  logic [hf_pkg::SpW-1:0]  s_q;
  logic [hf_pkg::HW-1:0]   h_q, a_q, b_q, c_q, d_q, e_q, f_q, g_q, rdat_q;
  logic [hf_pkg::HW-1:0]   mem_q [hf_pkg::MemDepth];
  logic [hf_pkg::AddrW-1:0] raddr;
  logic accept;
  logic [hf_pkg::CntW-1:0] y, xm, xp, ym, x2, xm2;
  logic e2, e3;

  function automatic logic signed [hf_pkg::DhW-1:0] diff(input logic [hf_pkg::HW-1:0] p,
                                                         input logic [hf_pkg::HW-1:0] m);
    return $signed({p[hf_pkg::HW-1], p}) - $signed({m[hf_pkg::HW-1], m});
  endfunction

  always_comb begin
    if (cpe_q == '0) n_eff = 7'd1;
    else if (cpe_q > 7'(hf_pkg::MaxCells)) n_eff = 7'(hf_pkg::MaxCells);
    else n_eff = cpe_q;
  end

  assign accept = push_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  // neighbour indices of the item in flight
  assign y   = cy_q - 7'd1;
  assign xm  = (cx_q != '0) ? cx_q - 7'd1 : '0;
  assign xp  = (cx_q < n_q) ? cx_q + 7'd1 : n_q;
  assign ym  = (y != '0) ? y - 7'd1 : '0;
  assign x2  = cx_q - 7'd1;
  assign xm2 = (x2 != '0) ? x2 - 7'd1 : '0;
  assign e2  = (cy_q == n_q) && (cx_q != '0);
  assign e3  = (cy_q == n_q) && (cx_q == n_q);

  always_comb begin
    unique case (state_q)
      S_RA:    raddr = hf_pkg::mem_addr(y[0], xm);
      S_RB:    raddr = hf_pkg::mem_addr(y[0], xp);
      S_RC:    raddr = hf_pkg::mem_addr(ym[0], cx_q);
      S_RD:    raddr = hf_pkg::mem_addr(n_q[0], xm2);
      S_RE:    raddr = hf_pkg::mem_addr(~n_q[0], x2);
      S_RF:    raddr = hf_pkg::mem_addr(n_q[0], x2);
      S_RG:    raddr = hf_pkg::mem_addr(~n_q[0], n_q);
      default: raddr = '0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    job_push_o = 1'b0;
    job_o      = '0;
    job_o.sp   = s_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = (row_q != '0) ? S_RA : S_WR;
      S_RA:   state_d = S_RB;
      S_RB:   state_d = S_RC;
      S_RC:   state_d = S_CC;
      S_CC:   state_d = S_J1;
      S_J1: begin
        job_o.x    = cx_q;
        job_o.y    = y;
        job_o.dhx  = diff(b_q, a_q);
        job_o.dhy  = diff(h_q, c_q);
        job_o.kx2  = ((xp - xm) == 7'd2);
        job_o.ky2  = (y != '0);
        job_o.last = !e2;
        job_push_o = !job_full_i;
        if (!job_full_i) state_d = e2 ? S_RD : S_WR;
      end
      S_RD:   state_d = S_RE;
      S_RE:   state_d = S_RF;
      S_RF:   state_d = S_RG;
      S_RG:   state_d = S_CG;
      S_CG:   state_d = S_J2;
      S_J2: begin
        job_o.x    = x2;
        job_o.y    = n_q;
        job_o.dhx  = diff(h_q, d_q);
        job_o.dhy  = diff(f_q, e_q);
        job_o.kx2  = (x2 != '0);
        job_o.last = !e3;
        job_push_o = !job_full_i;
        if (!job_full_i) state_d = e3 ? S_J3 : S_WR;
      end
      S_J3: begin
        job_o.x    = n_q;
        job_o.y    = n_q;
        job_o.dhx  = diff(h_q, f_q);
        job_o.dhy  = diff(h_q, g_q);
        job_o.last = 1'b1;
        job_o.done = 1'b1;
        job_push_o = !job_full_i;
        if (!job_full_i) state_d = S_WR;
      end
      S_WR:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cpe_q   <= 7'd16;
      sp_q    <= 16'd256;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        if (col_q >= n_eff) begin
          col_q <= '0;
          row_q <= (row_q >= n_eff) ? '0 : row_q + 7'd1;
        end else begin
          col_q <= col_q + 7'd1;
        end
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          hf_pkg::CFG_CELLS: begin
            cpe_q <= cfg_data_i[hf_pkg::CntW-1:0];
            col_q <= '0;
            row_q <= '0;
          end
          hf_pkg::CFG_SPACING: sp_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // item latch and read captures
  always_ff @(posedge clk_i) begin
    if (accept) begin
      h_q  <= height_i;
      cx_q <= col_q;
      cy_q <= row_q;
      n_q  <= n_eff;
      s_q  <= (sp_q == '0) ? 16'd1 : sp_q;
    end
    if (state_q == S_RB) a_q <= rdat_q;
    if (state_q == S_RC) b_q <= rdat_q;
    if (state_q == S_CC) c_q <= rdat_q;
    if (state_q == S_RE) d_q <= rdat_q;
    if (state_q == S_RF) e_q <= rdat_q;
    if (state_q == S_RG) f_q <= rdat_q;
    if (state_q == S_CG) g_q <= rdat_q;
  end

  // line store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (state_q == S_WR) mem_q[hf_pkg::mem_addr(cy_q[0], cx_q)] <= h_q;
    rdat_q <= mem_q[raddr];
  end

endmodule

// File: sv/hf_jobq.sv
// ----------------------------------------------------------------------------
// hf_jobq
// Four-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module hf_jobq (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  hf_pkg::job_t data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output hf_pkg::job_t data_o
);

  hf_pkg::job_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  assign full_o  = (cnt_q == 3'd4);
  assign empty_o = (cnt_q == 3'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 2'd1;
      if (pop_i)  rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, push_i} - {2'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule

// File: sv/hf_norm.sv
// ----------------------------------------------------------------------------
// hf_norm
// Iterative vector normalizer: range shift, sum of squares, square root,
// three restoring divisions.
// ----------------------------------------------------------------------------
module hf_norm (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [hf_pkg::MagW-1:0]   m0_i,
  input  logic [hf_pkg::MagW-1:0]   m1_i,
  input  logic [hf_pkg::MagW-1:0]   m2_i,
  output logic                      done_o,
  output logic [hf_pkg::QW-1:0]     q0_o,
  output logic [hf_pkg::QW-1:0]     q1_o,
  output logic [hf_pkg::QW-1:0]     q2_o
);

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SQRT  = 3'd3;
  localparam logic [2:0] N_DIV0  = 3'd4;
  localparam logic [2:0] N_DIVS  = 3'd5;
  localparam logic [2:0] N_DONE  = 3'd6;

  logic [2:0] state_q;
  logic [hf_pkg::MagW-1:0] m_q [3];
  logic [hf_pkg::QW-1:0]   q_q [3];
  logic [1:0]  idx_q;
  logic [61:0] acc_q;
  logic [63:0] v_q, res_q;
  logic [4:0]  i_q;
  logic [31:0] r_q, rem_q;
  logic [13:0] qacc_q;
  logic [3:0]  cnt_q;
  logic        big;
  logic [59:0] sq;
  logic [63:0] bitv, trial;
  logic [31:0] rem2, mcur;
  logic        ge;

  assign big   = (m_q[0][hf_pkg::MagW-1:30] != '0) || (m_q[1][hf_pkg::MagW-1:30] != '0) ||
                 (m_q[2][hf_pkg::MagW-1:30] != '0);
  assign sq    = m_q[idx_q][29:0] * m_q[idx_q][29:0];
  assign bitv  = 64'd1 << {i_q, 1'b0};
  assign trial = res_q + bitv;
  assign rem2  = {rem_q[30:0], 1'b0};
  assign ge    = (rem2 >= r_q);
  assign mcur  = {2'b0, m_q[idx_q][29:0]};

  assign done_o = (state_q == N_DONE);
  assign q0_o   = q_q[0];
  assign q1_o   = q_q[1];
  assign q2_o   = q_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
    end else begin
      unique case (state_q)
        N_IDLE:  if (start_i) state_q <= N_SHIFT;
        N_SHIFT: if (!big) state_q <= N_SQ;
        N_SQ:    if (idx_q == 2'd2) state_q <= N_SQRT;
        N_SQRT:  if (i_q == '0) state_q <= N_DIV0;
        N_DIV0: begin
          if ((r_q != '0) && (mcur < r_q)) state_q <= N_DIVS;
          else if (idx_q == 2'd2) state_q <= N_DONE;
        end
        N_DIVS: begin
          if (cnt_q == 4'd1) state_q <= (idx_q == 2'd2) ? N_DONE : N_DIV0;
        end
        N_DONE:  state_q <= N_IDLE;
        default: state_q <= N_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      N_IDLE: begin
        m_q[0] <= m0_i;
        m_q[1] <= m1_i;
        m_q[2] <= m2_i;
        idx_q  <= '0;
        acc_q  <= '0;
      end
      N_SHIFT: begin
        if (big) begin
          m_q[0] <= m_q[0] >> 1;
          m_q[1] <= m_q[1] >> 1;
          m_q[2] <= m_q[2] >> 1;
        end
      end
      N_SQ: begin
        acc_q <= acc_q + {2'b0, sq};
        idx_q <= idx_q + 2'd1;
        if (idx_q == 2'd2) begin
          v_q   <= {2'b0, acc_q + {2'b0, sq}};
          res_q <= '0;
          i_q   <= 5'd31;
        end
      end
      N_SQRT: begin
        // one step of the digit-by-digit root per cycle
        if (v_q >= trial) begin
          v_q   <= v_q - trial;
          res_q <= (res_q >> 1) + bitv;
        end else begin
          res_q <= res_q >> 1;
        end
        i_q <= i_q - 5'd1;
        if (i_q == '0) begin
          r_q   <= (v_q >= trial) ? 32'((res_q >> 1) + bitv) : 32'(res_q >> 1);
          idx_q <= '0;
        end
      end
      N_DIV0: begin
        if (r_q == '0) begin
          q_q[idx_q] <= '0;
          idx_q      <= idx_q + 2'd1;
        end else if (mcur >= r_q) begin
          q_q[idx_q] <= '1;  // quotient reaches one: saturate
          idx_q      <= idx_q + 2'd1;
        end else begin
          rem_q  <= mcur;
          qacc_q <= '0;
          cnt_q  <= 4'd15;
        end
      end
      N_DIVS: begin
        rem_q  <= ge ? rem2 - r_q : rem2;
        qacc_q <= {qacc_q[12:0], ge};
        cnt_q  <= cnt_q - 4'd1;
        if (cnt_q == 4'd1) begin
          q_q[idx_q] <= {qacc_q, ge};
          idx_q      <= idx_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: sv/hf_back.sv
// ----------------------------------------------------------------------------
// hf_back
// Turns one job into a result: slope products, two normalizations, sign.
// ----------------------------------------------------------------------------
module hf_back (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         job_empty_i,
  input  hf_pkg::job_t job_i,
  output logic         job_pop_o,
  input  logic         pop_i,
  output logic         empty_o,
  output hf_pkg::res_t res_o
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL  = 3'd1;
  localparam logic [2:0] B_SN   = 3'd2;
  localparam logic [2:0] B_WN   = 3'd3;
  localparam logic [2:0] B_ST   = 3'd4;
  localparam logic [2:0] B_WT   = 3'd5;
  localparam logic [2:0] B_OUT  = 3'd6;

  logic [2:0] state_q;
  hf_pkg::job_t job_q;
  logic [1:0] mcnt_q;
  logic [hf_pkg::MagW-1:0] p_q [3];
  logic [hf_pkg::QW-1:0] nq_q [3];
  logic [hf_pkg::DistW-1:0] dx, dy, op_b;
  logic [23:0] op_a, adhx, adhy;
  logic [hf_pkg::DhW-1:0] ndhx, ndhy;
  logic [hf_pkg::MagW-1:0] prod, v0, v1, v2;
  logic nstart, ndone, load;
  logic [hf_pkg::QW-1:0] q0, q1, q2;
  logic res_valid_q;
  hf_pkg::res_t res_q;

  assign dx   = job_q.kx2 ? {job_q.sp, 1'b0} : {1'b0, job_q.sp};
  assign dy   = job_q.ky2 ? {job_q.sp, 1'b0} : {1'b0, job_q.sp};
  assign ndhx = -job_q.dhx;
  assign ndhy = -job_q.dhy;
  assign adhx = job_q.dhx[hf_pkg::DhW-1] ? ndhx[23:0] : job_q.dhx[23:0];
  assign adhy = job_q.dhy[hf_pkg::DhW-1] ? ndhy[23:0] : job_q.dhy[23:0];

  // one shared multiplier, taken in turn by the three products
  always_comb begin
    case (mcnt_q)
      2'd0:    begin op_a = adhx;        op_b = dy; end
      2'd1:    begin op_a = adhy;        op_b = dx; end
      default: begin op_a = {7'b0, dx}; op_b = dy; end
    endcase
  end
  assign prod = op_a * op_b;

  assign nstart = (state_q == B_SN) || (state_q == B_ST);
  always_comb begin
    if (state_q == B_ST) begin
      v0 = {24'b0, dx};
      v1 = '0;
      v2 = {17'b0, adhx};
    end else begin
      v0 = p_q[0];
      v1 = p_q[1];
      v2 = p_q[2];
    end
  end

  hf_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (nstart),
    .m0_i    (v0),
    .m1_i    (v1),
    .m2_i    (v2),
    .done_o  (ndone),
    .q0_o    (q0),
    .q1_o    (q1),
    .q2_o    (q2)
  );

  assign job_pop_o = (state_q == B_IDLE) && !job_empty_i;
  assign load      = (state_q == B_OUT) && (!res_valid_q || pop_i);
  assign empty_o   = !res_valid_q;
  assign res_o     = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        B_IDLE: if (!job_empty_i) state_q <= B_MUL;
        B_MUL:  if (mcnt_q == 2'd2) state_q <= B_SN;
        B_SN:   state_q <= B_WN;
        B_WN:   if (ndone) state_q <= B_ST;
        B_ST:   state_q <= B_WT;
        B_WT:   if (ndone) state_q <= B_OUT;
        B_OUT:  if (load) state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
      if (load) res_valid_q <= 1'b1;
      else if (pop_i) res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q  <= job_i;
      mcnt_q <= '0;
    end
    if (state_q == B_MUL) begin
      p_q[mcnt_q] <= prod;
      mcnt_q      <= mcnt_q + 2'd1;
    end
    if ((state_q == B_WN) && ndone) begin
      nq_q[0] <= q0;
      nq_q[1] <= q1;
      nq_q[2] <= q2;
    end
    if (load) begin
      res_q.x    <= job_q.x;
      res_q.y    <= job_q.y;
      res_q.nx   <= (job_q.dhx > 0) ? -$signed({1'b0, nq_q[0]}) : $signed({1'b0, nq_q[0]});
      res_q.ny   <= (job_q.dhy > 0) ? -$signed({1'b0, nq_q[1]}) : $signed({1'b0, nq_q[1]});
      res_q.nz   <= nq_q[2];
      res_q.tx   <= q0;
      res_q.tz   <= job_q.dhx[hf_pkg::DhW-1] ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
      res_q.last <= job_q.last;
      res_q.done <= job_q.done;
    end
  end

endmodule

// File: sv/heightfield_normal_tangent_unit.sv
// ----------------------------------------------------------------------------
// heightfield_normal_tangent_unit
// Per-vertex unit normal and tangent of a raster-ordered height grid.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | push / full          | height_i (signed Q15.8)
//  result  | empty / pop          | vert_x_o .. grid_done_o
//  config  | cfg_valid_i/ready_o  | cfg_index_i, cfg_data_i
//
//  Front: a beat in row 0 only writes the line store; any other beat reads its
//  neighbours in turn from the single-port line store and issues a job, and a
//  beat in the last row up to three. Back: per result, the shared multiplier,
//  then a 32-step root and restoring divides, run twice (normal, tangent).
//  A four-deep job queue lets the front run ahead; a result held on the
//  outputs stalls the back, a full queue stalls the front and so push.
//  Reset is asynchronous; the line store has no reset and needs no clearing.
module heightfield_normal_tangent_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic signed [23:0]          height_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [6:0]                  vert_x_o,
  output logic [6:0]                  vert_y_o,
  output logic signed [15:0]          normal_x_o,
  output logic signed [15:0]          normal_y_o,
  output logic [14:0]                 normal_z_o,
  output logic [14:0]                 tangent_x_o,
  output logic signed [15:0]          tangent_z_o,
  output logic                        run_last_o,
  output logic                        grid_done_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [hf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hf_pkg::CfgDataW-1:0] cfg_data_i
);

  logic         busy, jq_push, jq_full, jq_pop, jq_empty;
  hf_pkg::job_t jq_in, jq_out;
  hf_pkg::res_t res;

  // registers are always writable; writes must come only while idle, which the block does not enforce
  assign cfg_ready_o = 1'b1;
  assign full        = busy;

  hf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .busy_o      (busy),
    .height_i    (height_i),
    .job_push_o  (jq_push),
    .job_o       (jq_in),
    .job_full_i  (jq_full)
  );

  hf_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (jq_push),
    .data_i  (jq_in),
    .full_o  (jq_full),
    .pop_i   (jq_pop),
    .empty_o (jq_empty),
    .data_o  (jq_out)
  );

  hf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (jq_empty),
    .job_i       (jq_out),
    .job_pop_o   (jq_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign vert_x_o    = res.x;
  assign vert_y_o    = res.y;
  assign normal_x_o  = res.nx;
  assign normal_y_o  = res.ny;
  assign normal_z_o  = res.nz;
  assign tangent_x_o = res.tx;
  assign tangent_z_o = res.tz;
  assign run_last_o  = res.last;
  assign grid_done_o = res.done;

endmodule

// File: sv/hf_checker.sv
// ----------------------------------------------------------------------------
// hf_checker
// Port-level checks of the heightfield normal unit, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [6:0] vert_x_o,
  input logic [6:0] vert_y_o,
  input logic       run_last_o,
  input logic       grid_done_o
);

  // the grid's final vertex closes its beat's run
  `HF_ASSERT(a_done_is_last, (!empty && grid_done_o) |-> run_last_o, "grid_done without run_last")
  // the grid's final vertex sits on the diagonal corner
  `HF_ASSERT(a_done_corner, (!empty && grid_done_o) |-> (vert_x_o == vert_y_o), "done off corner")
  // a waiting result is not withdrawn
  `HF_ASSERT_NEXT(a_res_holds, (!empty && !pop), !empty, "result dropped without pop")

endmodule

bind heightfield_normal_tangent_unit hf_checker u_hf_checker (.*);
